### rtl/feedforward_pi_flow_controller_defines.svh
// assertion macros for the flow controller checker
`ifndef FEEDFORWARD_PI_FLOW_CONTROLLER_DEFINES_SVH
`define FEEDFORWARD_PI_FLOW_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define FFPI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffpi check failed");

// next-cycle implication
`define FFPI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffpi check failed");

`endif

### rtl/ffpi_pkg.sv
`default_nettype none

package ffpi_pkg;

    localparam int CHANNELS     = 2;
    localparam int CH_W         = 1;
    localparam int TABLE_POINTS = 7;

    localparam int SP_W    = 15;
    localparam int GAIN_W  = 24;
    localparam int BPH_W   = 16;
    localparam int DRV_W   = 8;
    localparam int IVL_W   = 16;
    localparam int TIME_W  = 32;
    localparam int FLOW_W  = 16;
    localparam int INTEG_W = 48;
    localparam int HZ_W    = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int ERR_W      = 18;
    localparam int NUM_W      = 19;
    localparam int DEN_W      = 13;
    localparam int FRAC_W     = 24;
    localparam int PROP_SHIFT = 8;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 34;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int NI_W       = 60;
    localparam int ACC_W      = 52;
    localparam int QUO_W      = 8;
    localparam int DIVN_W     = 35;
    localparam int DIVD_W     = DEN_W + 8;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_CH0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_CH1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_HZ  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS  = CFG_IDX_W'(6);

    localparam logic [BPH_W-1:0] BPH_RESET = BPH_W'(256);
    localparam logic [DRV_W-1:0] MAX_RESET = DRV_W'(255);
    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(100);

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // flow breakpoints in tenths and the matching frequencies
    localparam logic [SP_W-1:0] FLOW_PTS [TABLE_POINTS] = '{
        15'd3500, 15'd6500, 15'd9000, 15'd13500, 15'd15500, 15'd19500, 15'd22500
    };
    localparam logic [HZ_W-1:0] HZ_PTS [TABLE_POINTS] = '{
        7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd75, 7'd100
    };

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic [TIME_W-1:0]        now_ms;
        logic signed [FLOW_W-1:0] measured_flow;
    } t_in_item;

    typedef struct packed {
        logic [DRV_W-1:0] drive_byte;
        logic             updated;
        logic             saturated;
    } t_out_item;

    typedef struct packed {
        logic [SP_W-1:0]          setpoint_ch0;
        logic [SP_W-1:0]          setpoint_ch1;
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic [BPH_W-1:0]         bits_per_hz;
        logic [DRV_W-1:0]         max_drive;
        logic [IVL_W-1:0]         interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]         last_update_time;
        logic signed [INTEG_W-1:0] integral_sum;
        logic [DRV_W-1:0]          last_drive;
    } t_chan_state;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DRV_W-1:0] ff;
    } t_div_rsp;

endpackage

`default_nettype wire

### rtl/ffpi_cfg_regs.sv
`default_nettype none

module ffpi_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ffpi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffpi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ffpi_pkg::t_cfg                   o_cfg,
    output logic [ffpi_pkg::CHANNELS-1:0]    o_clear
);
    import ffpi_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{setpoint_ch0: '0, setpoint_ch1: '0, prop_gain: '0, integ_gain: '0,
                       bits_per_hz: BPH_RESET, max_drive: MAX_RESET,
                       interval_ms: IVL_RESET};
        end else if (wr) begin
            case (i_cfg_index)
                REG_SETPOINT_CH0: r_cfg.setpoint_ch0 <= i_cfg_data[SP_W-1:0];
                REG_SETPOINT_CH1: r_cfg.setpoint_ch1 <= i_cfg_data[SP_W-1:0];
                REG_PROP_GAIN:    r_cfg.prop_gain    <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_INTEG_GAIN:   r_cfg.integ_gain   <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_BITS_PER_HZ:  r_cfg.bits_per_hz  <= i_cfg_data[BPH_W-1:0];
                REG_MAX_DRIVE:    r_cfg.max_drive    <= i_cfg_data[DRV_W-1:0];
                REG_INTERVAL_MS:  r_cfg.interval_ms  <= i_cfg_data[IVL_W-1:0];
                default: ;
            endcase
        end
    end

    // a setpoint write restarts that channel
    always_comb begin
        o_clear = '0;
        if (wr) begin
            if (i_cfg_index == REG_SETPOINT_CH0) begin
                o_clear[0] = 1'b1;
            end
            if (i_cfg_index == REG_SETPOINT_CH1) begin
                o_clear[1] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ffpi_state_mem.sv
`default_nettype none

module ffpi_state_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [ffpi_pkg::CH_W-1:0]      i_rd_addr,
    output ffpi_pkg::t_chan_state          o_rd_data,
    input  logic                           i_wr_en,
    input  logic [ffpi_pkg::CH_W-1:0]      i_wr_addr,
    input  ffpi_pkg::t_chan_state          i_wr_data,
    input  logic [ffpi_pkg::CHANNELS-1:0]  i_clear
);
    import ffpi_pkg::*;

    t_chan_state          r_mem [CHANNELS];
    t_chan_state          r_rd_data;
    logic                 r_rd_valid;
    logic [CHANNELS-1:0]  r_valid;
    logic [CHANNELS-1:0]  wr_mask;

    assign wr_mask   = i_wr_en ? (CHANNELS'(1) << i_wr_addr) : '0;
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid <= (r_valid & ~i_clear) | wr_mask;
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ffpi_ffdiv.sv
`default_nettype none

module ffpi_ffdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ffpi_pkg::t_div_req i_req,
    output ffpi_pkg::t_div_rsp o_rsp
);
    import ffpi_pkg::*;

    localparam int DIV_STEPS = QUO_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    logic [DIVN_W-1:0] r_rem;
    logic [DIVN_W-1:0] r_dsh;
    logic [CNT_W-1:0]  r_cnt;
    logic [QUO_W-1:0]  r_q;
    logic              r_busy;
    logic              r_done;
    logic              r_sat;
    logic              ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_STEPS)) begin
                if (ge) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // first step checks the 255 ceiling, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dsh <= DIVN_W'({i_req.divisor, {QUO_W{1'b0}}});
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            if (r_cnt == CNT_W'(DIV_STEPS)) begin
                r_sat <= ge;
            end else begin
                r_q <= {r_q[QUO_W-2:0], ge};
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_sat) begin
            o_rsp.ff = '1;
        end else if (r_q == '0) begin
            o_rsp.ff = DRV_W'(1);
        end else begin
            o_rsp.ff = r_q;
        end
    end

endmodule

`default_nettype wire

### rtl/feedforward_pi_flow_controller.sv
// channel   direction  handshake              payload
// in        input      i_in_valid/o_in_stall  i_in_item  (channel, now_ms, measured_flow)
// out       output     o_out_valid/i_out_stall o_out_item (drive_byte, updated, saturated)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// an update item steps through load, the multiply states M1 to M6 and a wait on the
// feedforward divider (range check plus one quotient bit a cycle), which ends early
// when the range check finds the 255 ceiling; a repeat item goes from load to done
// per-channel state lives in a two-entry memory, read at transfer in, written back once
// synchronous active-low reset; state entries read as zero until written, no clear pass
// o_in_stall is high while an item is in work; a finished result waits if out is stalled
`default_nettype none

module feedforward_pi_flow_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ffpi_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ffpi_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ffpi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffpi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ffpi_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_M4   = 4'd5;
    localparam logic [3:0] S_M5   = 4'd6;
    localparam logic [3:0] S_M6   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1);

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    t_in_item                  r_item;
    t_cfg                      cfg;
    logic [CHANNELS-1:0]       clear;
    t_chan_state               rd_entry;
    t_chan_state               r_entry;
    t_chan_state               wr_entry;
    logic                      wr_en;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic                      in_accept;
    logic                      out_free;

    logic [TIME_W-1:0]         r_dt;
    logic signed [ERR_W-1:0]   r_err;
    logic [NUM_W-1:0]          r_num;
    logic [DEN_W-1:0]          r_den;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [INTEG_W-1:0] r_ni;
    logic signed [ACC_W-1:0]   r_part;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_frac_nz;
    t_out_item                 r_res;
    t_out_item                 r_out;
    logic                      r_out_valid;

    logic [SP_W-1:0]           sp;
    logic                      first_run;
    logic [TIME_W-1:0]         elapsed;
    logic                      rep;
    logic [TIME_W-1:0]         dt_in;
    logic signed [ERR_W-1:0]   err_in;
    logic [NUM_W-1:0]          seg_base;
    logic [SP_W-1:0]           seg_lo;
    logic [HZ_W-1:0]           seg_slope;
    logic [DEN_W-1:0]          seg_den;
    logic [NUM_W-1:0]          interp;
    logic [NUM_W-1:0]          num_in;
    logic [DEN_W-1:0]          den_in;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [NI_W-1:0]    ni_sum;
    logic signed [INTEG_W-1:0] ni_sat;

    logic signed [ACC_W-1:0]   a_val;
    logic [DRV_W-1:0]          top_v;
    logic signed [ACC_W-1:0]   top_s;
    logic                      lt1;
    logic                      hi;
    logic [DRV_W-1:0]          drive;
    logic                      sat;

    ffpi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clear     (clear)
    );

    ffpi_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_in_item.channel),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_item.channel),
        .i_wr_data (wr_entry),
        .i_clear   (clear)
    );

    ffpi_ffdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // time step, error and repeat decision
    always_comb begin
        sp        = (r_item.channel == 1'b1) ? cfg.setpoint_ch1 : cfg.setpoint_ch0;
        first_run = (rd_entry.last_update_time == '0);
        elapsed   = r_item.now_ms - rd_entry.last_update_time;
        rep       = !first_run && (elapsed < TIME_W'(cfg.interval_ms));
        dt_in     = first_run ? TIME_W'(cfg.interval_ms) : elapsed;
        err_in    = $signed({{(ERR_W-SP_W){1'b0}}, sp})
                  - $signed({{(ERR_W-FLOW_W){r_item.measured_flow[FLOW_W-1]}},
                             r_item.measured_flow});
    end

    // feedforward segment as numerator over denominator
    always_comb begin
        seg_base  = '0;
        seg_lo    = '0;
        seg_slope = '0;
        seg_den   = '0;
        for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
            if (sp <= FLOW_PTS[i+1]) begin
                seg_base  = NUM_W'(int'(HZ_PTS[i]) * int'(FLOW_PTS[i+1] - FLOW_PTS[i]));
                seg_lo    = FLOW_PTS[i];
                seg_slope = HZ_PTS[i+1] - HZ_PTS[i];
                seg_den   = DEN_W'(FLOW_PTS[i+1] - FLOW_PTS[i]);
            end
        end
        interp = {{(NUM_W-SP_W){1'b0}}, sp - seg_lo} * {{(NUM_W-HZ_W){1'b0}}, seg_slope};
        if (sp <= FLOW_PTS[0]) begin
            num_in = NUM_W'(HZ_PTS[0]);
            den_in = DEN_W'(1);
        end else if (sp >= FLOW_PTS[TABLE_POINTS-1]) begin
            num_in = NUM_W'(HZ_PTS[TABLE_POINTS-1]);
            den_in = DEN_W'(1);
        end else begin
            num_in = seg_base + interp;
            den_in = seg_den;
        end
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M1: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = $signed(MUL_B_W'(r_dt));
            end
            S_M2: begin
                mul_a = $signed(MUL_A_W'(r_num));
                mul_b = $signed(MUL_B_W'(cfg.bits_per_hz));
            end
            S_M3: begin
                mul_a = MUL_A_W'(cfg.prop_gain);
                mul_b = MUL_B_W'(r_err);
            end
            S_M4: begin
                mul_a = MUL_A_W'(cfg.integ_gain);
                mul_b = $signed(MUL_B_W'(r_ni[FRAC_W-1:0]));
            end
            S_M5: begin
                mul_a = MUL_A_W'(cfg.integ_gain);
                mul_b = MUL_B_W'($signed(r_ni[INTEG_W-1:FRAC_W]));
            end
            default: ;
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // integral update with saturation
    always_comb begin
        ni_sum = NI_W'(r_entry.integral_sum) + NI_W'(r_prod);
        if (ni_sum > NI_W'(INTEG_MAX)) begin
            ni_sat = INTEG_MAX;
        end else if (ni_sum < NI_W'(INTEG_MIN)) begin
            ni_sat = INTEG_MIN;
        end else begin
            ni_sat = ni_sum[INTEG_W-1:0];
        end
    end

    // output clamp
    always_comb begin
        a_val = r_acc + ACC_W'($signed({1'b0, div_rsp.ff}));
        top_v = (cfg.max_drive == '0) ? DRV_W'(1) : cfg.max_drive;
        top_s = $signed(ACC_W'(top_v));
        lt1   = (a_val < ACC_ONE);
        hi    = (a_val > top_s) || ((a_val == top_s) && r_frac_nz);
        sat   = lt1 || hi;
        if (lt1) begin
            drive = DRV_W'(1);
        end else if (hi) begin
            drive = top_v;
        end else begin
            drive = a_val[DRV_W-1:0];
        end
        wr_entry.last_update_time = r_item.now_ms;
        wr_entry.integral_sum     = sat ? r_entry.integral_sum : r_ni;
        wr_entry.last_drive       = drive;
    end

    assign wr_en            = (r_state == S_FIN) && div_rsp.done;
    assign div_req.start    = (r_state == S_M3);
    assign div_req.dividend = r_prod[DIVN_W-1:0];
    assign div_req.divisor  = {r_den, 8'b0};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_accept) n_state = S_LOAD;
            S_LOAD: n_state = rep ? S_DONE : S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_M6;
            S_M6:   n_state = S_FIN;
            S_FIN:  if (div_rsp.done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_item;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
        r_prod <= mul_p;
        case (r_state)
            S_LOAD: begin
                r_entry <= rd_entry;
                r_dt    <= dt_in;
                r_err   <= err_in;
                r_num   <= num_in;
                r_den   <= den_in;
                r_res   <= '{drive_byte: rd_entry.last_drive, updated: 1'b0,
                             saturated: 1'b0};
            end
            S_M2: r_ni <= ni_sat;
            S_M4: r_part <= ACC_W'(r_prod) <<< PROP_SHIFT;
            S_M5: r_part <= r_part + ACC_W'(r_prod);
            S_M6: begin
                r_acc     <= ACC_W'(r_prod) + (r_part >>> FRAC_W);
                r_frac_nz <= |r_part[FRAC_W-1:0];
            end
            S_FIN: begin
                if (div_rsp.done) begin
                    r_res <= '{drive_byte: drive, updated: 1'b1, saturated: sat};
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/ffpi_checker.sv
`default_nettype none
`include "feedforward_pi_flow_controller_defines.svh"

module ffpi_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input ffpi_pkg::t_out_item             o_out_item
);
    import ffpi_pkg::*;

    // one item in work at a time
    `FFPI_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a new result only appears as the work on an item ends
    `FFPI_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    // an update never drives below one
    `FFPI_ASSERT_IMP(a_drive_floor, i_clk, i_rst_n, o_out_valid && o_out_item.updated, o_out_item.drive_byte != '0)

    `FFPI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

endmodule

bind feedforward_pi_flow_controller ffpi_checker u_ffpi_checker (.*);

`default_nettype wire
